### rtl/audio_ducking_gain_ramp_unit_assert.svh
// Assertion macros for the ducking gain ramp back end
`ifndef AUDIO_DUCKING_GAIN_RAMP_UNIT_ASSERT_SVH
`define AUDIO_DUCKING_GAIN_RAMP_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define ADGR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("adgr: same-cycle check failed");

// next-cycle implication, checked out of reset
`define ADGR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("adgr: next-cycle check failed");

`endif

### rtl/adgr_pkg.sv
// Types, constants and gain table for the ducking gain ramp
package adgr_pkg;

    localparam int SAMPLE_W         = 16;
    localparam int DB_W             = 6;
    localparam int RAMP_BITS        = 24;
    localparam int GAIN_W           = 15;
    localparam int GAIN_FRAC        = 15;
    localparam int GAIN_ENTRIES_DEF = 51;
    localparam int QUEUE_DEPTH      = 2;

    typedef enum logic
    {
        KIND_SAMPLE = 1'b0,
        KIND_DUCK   = 1'b1
    } item_kind_t;

    typedef enum logic
    {
        BK_RUN = 1'b0,
        BK_DIV = 1'b1
    } back_state_t;

    typedef struct packed
    {
        logic                        req_type;
        logic signed [SAMPLE_W-1:0]  sample_in;
        logic [DB_W-1:0]             target_db;
        logic [RAMP_BITS-1:0]        ramp_samples;
    } req_item_t;

    typedef struct packed
    {
        logic signed [SAMPLE_W-1:0]  sample_out;
        logic [DB_W-1:0]             applied_db;
        logic                        ramping;
    } rsp_item_t;

    typedef struct packed
    {
        item_kind_t                  kind;
        logic signed [SAMPLE_W-1:0]  sample;
        logic [DB_W-1:0]             target;
        logic [RAMP_BITS-1:0]        ramp;
    } q_item_t;

    typedef struct packed
    {
        logic                  start;
        logic [RAMP_BITS-1:0]  dividend;
        logic [DB_W-1:0]       divisor;
    } div_req_t;

    typedef struct packed
    {
        logic                  done;
        logic [RAMP_BITS-1:0]  quotient;
        logic [DB_W-1:0]       remainder;
    } div_res_t;

    function automatic logic [DB_W-1:0] move_level(input logic [DB_W-1:0] lv,
                                                   input logic down);
        logic [DB_W-1:0] res;
        begin
            if (down)
            begin
                res = lv - DB_W'(1);
            end
            else
            begin
                res = lv + DB_W'(1);
            end
            return res;
        end
    endfunction

    function automatic logic [GAIN_W-1:0] gain_q15(input logic [DB_W-1:0] db);
        logic [GAIN_W-1:0] g;
        begin
            case (db)
                6'd0:    g = 15'd32767;
                6'd1:    g = 15'd29201;
                6'd2:    g = 15'd26022;
                6'd3:    g = 15'd23189;
                6'd4:    g = 15'd20665;
                6'd5:    g = 15'd18415;
                6'd6:    g = 15'd16410;
                6'd7:    g = 15'd14624;
                6'd8:    g = 15'd13032;
                6'd9:    g = 15'd11613;
                6'd10:   g = 15'd10349;
                6'd11:   g = 15'd9222;
                6'd12:   g = 15'd8218;
                6'd13:   g = 15'd7324;
                6'd14:   g = 15'd6527;
                6'd15:   g = 15'd5816;
                6'd16:   g = 15'd5183;
                6'd17:   g = 15'd4619;
                6'd18:   g = 15'd4116;
                6'd19:   g = 15'd3668;
                6'd20:   g = 15'd3269;
                6'd21:   g = 15'd2913;
                6'd22:   g = 15'd2596;
                6'd23:   g = 15'd2313;
                6'd24:   g = 15'd2061;
                6'd25:   g = 15'd1837;
                6'd26:   g = 15'd1637;
                6'd27:   g = 15'd1459;
                6'd28:   g = 15'd1300;
                6'd29:   g = 15'd1158;
                6'd30:   g = 15'd1032;
                6'd31:   g = 15'd920;
                6'd32:   g = 15'd820;
                6'd33:   g = 15'd731;
                6'd34:   g = 15'd651;
                6'd35:   g = 15'd580;
                6'd36:   g = 15'd517;
                6'd37:   g = 15'd461;
                6'd38:   g = 15'd411;
                6'd39:   g = 15'd366;
                6'd40:   g = 15'd326;
                6'd41:   g = 15'd291;
                6'd42:   g = 15'd259;
                6'd43:   g = 15'd231;
                6'd44:   g = 15'd206;
                6'd45:   g = 15'd183;
                6'd46:   g = 15'd163;
                6'd47:   g = 15'd146;
                6'd48:   g = 15'd130;
                6'd49:   g = 15'd116;
                6'd50:   g = 15'd103;
                default: g = '0;
            endcase
            return g;
        end
    endfunction

endpackage

### rtl/audio_ducking_gain_ramp_unit.sv
// A sample passes through the queue, the scale stage and the result register.
// Throughput: one audio sample per cycle while the result side keeps up and no ramp division runs.
// A duck command needing no ramp is popped without holding the back end; a ramping one
// holds sample processing until the bit-serial divider reports its result.
// Reset clears the level, goal, ramp counters, queue and pipeline valids at once.
// Top level of the ducking gain ramp: front queue, back end and divider
module audio_ducking_gain_ramp_unit #(
    parameter int GAIN_ENTRIES = adgr_pkg::GAIN_ENTRIES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  adgr_pkg::req_item_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output adgr_pkg::rsp_item_t rsp
);

    logic               q_valid;
    logic               q_ready;
    adgr_pkg::q_item_t  q_item;
    adgr_pkg::div_req_t div_req;
    adgr_pkg::div_res_t div_res;

    adgr_front #(
        .GAIN_ENTRIES (GAIN_ENTRIES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item)
    );

    adgr_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .div_req (div_req),
        .div_res (div_res)
    );

    adgr_back #(
        .GAIN_ENTRIES (GAIN_ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .div_req   (div_req),
        .div_res   (div_res),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

### rtl/adgr_front.sv
// Front end: accepts transactions, classifies them and queues them for the back end
module adgr_front #(
    parameter int GAIN_ENTRIES = adgr_pkg::GAIN_ENTRIES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  adgr_pkg::req_item_t req,
    output logic               q_valid,
    input  logic               q_ready,
    output adgr_pkg::q_item_t  q_item
);

    localparam int PTR_W = $clog2(adgr_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(adgr_pkg::QUEUE_DEPTH + 1);

    adgr_pkg::q_item_t   mem [adgr_pkg::QUEUE_DEPTH];
    adgr_pkg::q_item_t   cls_item;
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic                push;
    logic                pop;

    assign req_ready = (cnt_reg != CNT_W'(adgr_pkg::QUEUE_DEPTH));
    assign q_valid   = (cnt_reg != '0);
    assign q_item    = mem[rd_ptr_reg];
    assign push      = req_valid && req_ready;
    assign pop       = q_valid && q_ready;

    // classify and clamp the target to the table
    always_comb
    begin
        cls_item.kind   = req.req_type ? adgr_pkg::KIND_DUCK : adgr_pkg::KIND_SAMPLE;
        cls_item.sample = req.sample_in;
        cls_item.ramp   = req.ramp_samples;
        if (req.target_db > adgr_pkg::DB_W'(GAIN_ENTRIES - 1))
        begin
            cls_item.target = adgr_pkg::DB_W'(GAIN_ENTRIES - 1);
        end
        else
        begin
            cls_item.target = req.target_db;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(adgr_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(adgr_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= cls_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

### rtl/adgr_div.sv
// Bit-serial restoring divider for the samples-per-step figure
module adgr_div (
    input  logic               clk,
    input  logic               rst_n,
    input  adgr_pkg::div_req_t div_req,
    output adgr_pkg::div_res_t div_res
);

    localparam int RB    = adgr_pkg::RAMP_BITS;
    localparam int DW    = adgr_pkg::DB_W;
    localparam int CNT_W = $clog2(RB);

    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [RB-1:0]    quo_reg;
    logic [RB-1:0]    quo_next;
    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    rem_next;
    logic [DW-1:0]    dvs_reg;
    logic [DW-1:0]    dvs_next;
    logic [DW:0]      shifted;
    logic [DW:0]      diff;
    logic             fits;

    assign shifted = {rem_reg, quo_reg[RB-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = (shifted >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (div_req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = div_req.dividend;
            rem_next  = '0;
            dvs_next  = div_req.divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[RB-2:0], fits};
            rem_next = fits ? diff[DW-1:0] : shifted[DW-1:0];
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(RB - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign div_res.done      = done_reg;
    assign div_res.quotient  = quo_reg;
    assign div_res.remainder = rem_reg;

endmodule

### rtl/adgr_back.sv
// Back end: ducking state, ramp stepping, gain scaling and output register
`include "audio_ducking_gain_ramp_unit_assert.svh"

module adgr_back #(
    parameter int GAIN_ENTRIES = adgr_pkg::GAIN_ENTRIES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_ready,
    input  adgr_pkg::q_item_t   q_item,
    output adgr_pkg::div_req_t  div_req,
    input  adgr_pkg::div_res_t  div_res,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output adgr_pkg::rsp_item_t rsp
);

    localparam int SW = adgr_pkg::SAMPLE_W;
    localparam int DW = adgr_pkg::DB_W;
    localparam int RB = adgr_pkg::RAMP_BITS;
    localparam int GW = adgr_pkg::GAIN_W;
    localparam int PW = SW + GW + 1;

    adgr_pkg::back_state_t state_reg;
    adgr_pkg::back_state_t state_next;

    logic [DW-1:0]          level_reg;
    logic [DW-1:0]          level_next;
    logic [DW-1:0]          goal_reg;
    logic [DW-1:0]          goal_next;
    logic [RB-1:0]          ramp_left_reg;
    logic [RB-1:0]          ramp_left_next;
    logic [RB-1:0]          step_len_reg;
    logic [RB-1:0]          step_len_next;
    logic [RB-1:0]          step_left_reg;
    logic [RB-1:0]          step_left_next;
    logic                   step_down_reg;
    logic                   step_down_next;
    logic [RB-1:0]          cmd_ramp_reg;
    logic [RB-1:0]          cmd_ramp_next;

    logic                   a_valid_reg;
    logic                   a_valid_next;
    logic signed [SW-1:0]   a_x_reg;
    logic signed [SW-1:0]   a_x_next;
    logic [GW-1:0]          a_gain_reg;
    logic [GW-1:0]          a_gain_next;
    logic                   a_bypass_reg;
    logic                   a_bypass_next;
    logic [DW-1:0]          a_db_reg;
    logic [DW-1:0]          a_db_next;
    logic                   a_act_reg;
    logic                   a_act_next;

    logic                   b_valid_reg;
    logic                   b_valid_next;
    adgr_pkg::rsp_item_t    b_data_reg;
    adgr_pkg::rsp_item_t    b_data_next;

    logic                   b_adv;
    logic                   a_adv;
    logic                   is_duck;
    logic                   pop;
    logic                   pop_sample;
    logic                   pop_cmd;
    logic                   same;
    logic                   go_up;
    logic [DW-1:0]          diff;
    logic [DW-1:0]          steps;
    logic                   go_ramp;
    logic                   active;
    logic [RB-1:0]          sl_dec;
    logic signed [PW-1:0]   prod;

    assign is_duck    = (q_item.kind == adgr_pkg::KIND_DUCK);
    assign b_adv      = !b_valid_reg || rsp_ready;
    assign a_adv      = !a_valid_reg || b_adv;
    assign pop        = q_valid && q_ready;
    assign pop_sample = pop && !is_duck;
    assign pop_cmd    = pop && is_duck;

    assign same    = (q_item.target == goal_reg);
    assign go_up   = (q_item.target > goal_reg);
    assign diff    = go_up ? (q_item.target - goal_reg) : (goal_reg - q_item.target);
    assign steps   = diff - DW'(1);
    assign go_ramp = (q_item.ramp != '0) && (steps != '0);
    assign active  = (ramp_left_reg != '0);
    assign sl_dec  = (step_left_reg != '0) ? (step_left_reg - RB'(1)) : '0;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            adgr_pkg::BK_RUN:
            begin
                if (pop_cmd && !same && go_ramp)
                begin
                    state_next = adgr_pkg::BK_DIV;
                end
            end
            adgr_pkg::BK_DIV:
            begin
                if (div_res.done)
                begin
                    state_next = adgr_pkg::BK_RUN;
                end
            end
            default:
            begin
                state_next = adgr_pkg::BK_RUN;
            end
        endcase
    end

    always_comb
    begin
        q_ready          = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = q_item.ramp;
        div_req.divisor  = steps;
        case (state_reg)
            adgr_pkg::BK_RUN:
            begin
                q_ready       = is_duck || a_adv;
                div_req.start = q_valid && is_duck && !same && go_ramp;
            end
            adgr_pkg::BK_DIV:
            begin
                q_ready = 1'b0;
            end
            default:
            begin
                q_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        level_next     = level_reg;
        goal_next      = goal_reg;
        ramp_left_next = ramp_left_reg;
        step_len_next  = step_len_reg;
        step_left_next = step_left_reg;
        step_down_next = step_down_reg;
        cmd_ramp_next  = cmd_ramp_reg;
        a_valid_next   = a_valid_reg;
        a_x_next       = a_x_reg;
        a_gain_next    = a_gain_reg;
        a_bypass_next  = a_bypass_reg;
        a_db_next      = a_db_reg;
        a_act_next     = a_act_reg;

        if (a_adv)
        begin
            a_valid_next = pop_sample;
        end

        if (pop_sample)
        begin
            a_x_next      = q_item.sample;
            a_gain_next   = adgr_pkg::gain_q15(level_reg);
            a_bypass_next = !active && (level_reg == '0);
            a_db_next     = level_reg;
            a_act_next    = active;
            if (active)
            begin
                ramp_left_next = ramp_left_reg - RB'(1);
                if (sl_dec == '0)
                begin
                    level_next     = adgr_pkg::move_level(level_reg, step_down_reg);
                    step_left_next = step_len_reg;
                end
                else
                begin
                    step_left_next = sl_dec;
                end
            end
        end

        // snap to the old goal, then either jump or take the first step
        if (pop_cmd && !same)
        begin
            goal_next      = q_item.target;
            step_down_next = !go_up;
            ramp_left_next = '0;
            if (go_ramp)
            begin
                level_next    = adgr_pkg::move_level(goal_reg, !go_up);
                cmd_ramp_next = q_item.ramp;
            end
            else
            begin
                level_next = q_item.target;
            end
        end

        if (div_res.done)
        begin
            step_len_next  = div_res.quotient;
            step_left_next = div_res.quotient;
            ramp_left_next = cmd_ramp_reg - RB'(div_res.remainder);
        end
    end

    assign prod = a_x_reg * $signed({1'b0, a_gain_reg});

    always_comb
    begin
        b_valid_next = b_valid_reg;
        b_data_next  = b_data_reg;
        if (b_adv)
        begin
            b_valid_next = a_valid_reg;
            if (a_valid_reg)
            begin
                b_data_next.sample_out = a_bypass_reg ? a_x_reg :
                                         prod[adgr_pkg::GAIN_FRAC+SW-1:adgr_pkg::GAIN_FRAC];
                b_data_next.applied_db = a_db_reg;
                b_data_next.ramping    = a_act_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_ramp_reg <= cmd_ramp_next;
        a_x_reg      <= a_x_next;
        a_gain_reg   <= a_gain_next;
        a_bypass_reg <= a_bypass_next;
        a_db_reg     <= a_db_next;
        a_act_reg    <= a_act_next;
        b_data_reg   <= b_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= adgr_pkg::BK_RUN;
            level_reg     <= '0;
            goal_reg      <= '0;
            ramp_left_reg <= '0;
            step_len_reg  <= '0;
            step_left_reg <= '0;
            step_down_reg <= 1'b0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            goal_reg      <= goal_next;
            ramp_left_reg <= ramp_left_next;
            step_len_reg  <= step_len_next;
            step_left_reg <= step_left_next;
            step_down_reg <= step_down_next;
            a_valid_reg   <= a_valid_next;
            b_valid_reg   <= b_valid_next;
        end
    end

    assign rsp_valid = b_valid_reg;
    assign rsp       = b_data_reg;

    `ADGR_ASSERT_IMP(a_no_pop_in_div, state_reg == adgr_pkg::BK_DIV, !q_ready)
    `ADGR_ASSERT_IMP(a_done_in_div, div_res.done, state_reg == adgr_pkg::BK_DIV)
    `ADGR_ASSERT_IMP(a_level_range, 1'b1, {1'b0, level_reg} < (DW+1)'(GAIN_ENTRIES))
    `ADGR_ASSERT_NXT(a_ramp_step, ramp_left_reg != '0, step_left_reg != '0 || ramp_left_reg == '0)

endmodule
